FILE: hw/rtl/bdlp_pkg.sv
// Shared types and constants of the button debounce and long-press unit.
`default_nettype none
package bdlp_pkg;

   localparam int PIN_W      = 4;
   localparam int BTN_ID_W   = 3;
   localparam int KIND_W     = 2;
   localparam int TIME_W     = 32;
   localparam int MS_W       = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MAX_EVENTS = 4;
   localparam int SLOT_W     = 2;
   localparam int EVCNT_W    = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W     = 1;
   localparam int QCNT_W     = 2;

   // event kinds
   localparam logic [KIND_W-1:0] EV_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] EV_PRESS   = 2'd1;
   localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;
   localparam logic [KIND_W-1:0] EV_LONG    = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG     = 2'd2;

   localparam logic [MS_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [MS_W-1:0] LONG_RESET     = 16'd1000;

   // one classified tick handed from front to back
   typedef struct packed {
      logic [TIME_W-1:0] now;
      logic [PIN_W-1:0]  raw;
   } bdlp_tick_type;

endpackage
`default_nettype wire

FILE: hw/rtl/bdlp_req_if.sv
// Request channel interface: one millisecond tick with the pin levels.
`default_nettype none
interface bdlp_req_if
   import bdlp_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PIN_W-1:0] pin_levels;

   modport source (output valid, output pin_levels, input ready);
   modport sink   (input valid, input pin_levels, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/bdlp_rsp_if.sv
// Response channel interface: one button event per transaction.
`default_nettype none
interface bdlp_rsp_if
   import bdlp_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [BTN_ID_W-1:0] button_id;
   logic [KIND_W-1:0]   event_kind;
   logic [BTN_ID_W-1:0] changed_button;
   logic [PIN_W-1:0]    pressed_mask;
   logic                last;

   modport source (output valid, output button_id, output event_kind,
                   output changed_button, output pressed_mask, output last,
                   input ready);
   modport sink   (input valid, input button_id, input event_kind,
                   input changed_button, input pressed_mask, input last,
                   output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/bdlp_front.sv
// Front end: tick counter, pin edge detection and debounce lockout.
`default_nettype none
module bdlp_front
   import bdlp_pkg::*;
#(
   parameter int NUM_BUTTONS = 4
) (
   input  wire logic            clock,
   input  wire logic            reset,
   bdlp_req_if.sink             req,
   input  wire logic            enable,
   input  wire logic [MS_W-1:0] debounce_ms,
   input  wire logic            queue_full,
   output logic                 push,
   output bdlp_tick_type        push_data
);
   localparam int NB = (NUM_BUTTONS < PIN_W) ? NUM_BUTTONS : PIN_W;

   logic [TIME_W-1:0] tick_ff, tick_in;
   logic [PIN_W-1:0]  prev_ff;
   logic [PIN_W-1:0]  raw_ff, raw_in;
   logic [TIME_W-1:0] last_acc_ff [NB];
   logic [TIME_W-1:0] last_acc_in [NB];
   logic              accept;

   assign req.ready = !queue_full;
   assign accept    = req.valid && !queue_full;
   assign tick_in   = tick_ff + 32'd1;

   always_comb begin
      raw_in = raw_ff;
      for (int i = 0; i < NB; i++) begin
         last_acc_in[i] = last_acc_ff[i];
         if (((req.pin_levels[i] ^ prev_ff[i]) == 1'b1) && enable &&
             ((tick_in - last_acc_ff[i]) > {16'd0, debounce_ms})) begin
            raw_in[i]      = !req.pin_levels[i];
            last_acc_in[i] = tick_in;
         end
      end
   end

   assign push           = accept;
   assign push_data.now  = tick_in;
   assign push_data.raw  = raw_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         prev_ff <= '1;
         raw_ff  <= '0;
         for (int i = 0; i < NB; i++) last_acc_ff[i] <= '0;
      end else if (accept) begin
         tick_ff <= tick_in;
         prev_ff <= req.pin_levels;
         raw_ff  <= raw_in;
         for (int i = 0; i < NB; i++) last_acc_ff[i] <= last_acc_in[i];
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/bdlp_queue.sv
// Two-entry queue of classified ticks between front and back.
`default_nettype none
module bdlp_queue
   import bdlp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire bdlp_tick_type push_data,
   output logic               full,
   input  wire logic          pop,
   output logic               empty,
   output bdlp_tick_type      head
);
   bdlp_tick_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/bdlp_back.sv
// Back end: debounced state, button poll and event serialization.
`default_nettype none
module bdlp_back
   import bdlp_pkg::*;
#(
   parameter int NUM_BUTTONS = 4
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [MS_W-1:0] long_press_ms,
   input  wire logic            queue_empty,
   input  wire bdlp_tick_type   head,
   output logic                 pop,
   bdlp_rsp_if.source           rsp
);
   localparam int NB = (NUM_BUTTONS < PIN_W) ? NUM_BUTTONS : PIN_W;

   logic [NB-1:0]     deb_ff, deb_in;
   logic [NB-1:0]     done_ff, done_in;
   logic [TIME_W-1:0] start_ff [NB];
   logic [TIME_W-1:0] start_in [NB];
   logic [NB-1:0]     held_long;

   logic [BTN_ID_W-1:0] slot_btn_ff  [MAX_EVENTS];
   logic [KIND_W-1:0]   slot_kind_ff [MAX_EVENTS];
   logic [BTN_ID_W-1:0] slot_btn_in  [MAX_EVENTS];
   logic [KIND_W-1:0]   slot_kind_in [MAX_EVENTS];
   logic [SLOT_W-1:0]   last_idx_ff;
   logic [SLOT_W-1:0]   rd_idx_ff;
   logic [BTN_ID_W-1:0] changed_ff, changed_in;
   logic [PIN_W-1:0]    mask_ff, mask_in;
   logic                busy_ff;
   logic [EVCNT_W-1:0]  ev_cnt;
   logic                rsp_done;
   logic                final_out;

   // hold time check for every button against its stored press start
   always_comb begin
      for (int i = 0; i < NB; i++)
         held_long[i] = (head.now - start_ff[i]) >= {16'd0, long_press_ms};
   end

   // poll buttons in order; stops after the first debounced change
   always_comb begin
      logic stop;
      logic take_chg;
      logic lp_met;
      stop       = 1'b0;
      take_chg   = 1'b0;
      lp_met     = 1'b0;
      ev_cnt     = '0;
      changed_in = '0;
      deb_in     = deb_ff;
      done_in    = done_ff;
      for (int i = 0; i < NB; i++) start_in[i] = start_ff[i];
      for (int k = 0; k < MAX_EVENTS; k++) begin
         slot_btn_in[k]  = '0;
         slot_kind_in[k] = EV_NONE;
      end
      for (int i = 0; i < NB; i++) begin
         if (!stop) begin
            take_chg = (head.raw[i] != deb_ff[i]) &&
                       (ev_cnt < EVCNT_W'(MAX_EVENTS));
            if (take_chg) begin
               slot_btn_in[ev_cnt[SLOT_W-1:0]]  = BTN_ID_W'(i + 1);
               slot_kind_in[ev_cnt[SLOT_W-1:0]] = head.raw[i] ? EV_PRESS : EV_RELEASE;
               ev_cnt    = ev_cnt + 1'b1;
               deb_in[i] = head.raw[i];
               if (head.raw[i]) begin
                  start_in[i] = head.now;
                  done_in[i]  = 1'b0;
               end
            end
            // a fresh press has zero hold time
            lp_met = (take_chg && head.raw[i]) ? (long_press_ms == '0) : held_long[i];
            if (deb_in[i] && !done_in[i] && lp_met &&
                (ev_cnt < EVCNT_W'(MAX_EVENTS))) begin
               slot_btn_in[ev_cnt[SLOT_W-1:0]]  = BTN_ID_W'(i + 1);
               slot_kind_in[ev_cnt[SLOT_W-1:0]] = EV_LONG;
               ev_cnt     = ev_cnt + 1'b1;
               done_in[i] = 1'b1;
            end
            if (take_chg) begin
               stop       = 1'b1;
               changed_in = BTN_ID_W'(i + 1);
            end
         end
      end
      mask_in = '0;
      mask_in[NB-1:0] = deb_in;
   end

   assign final_out = (rd_idx_ff == last_idx_ff);
   assign rsp_done  = rsp.valid && rsp.ready;
   assign pop       = !queue_empty && (!busy_ff || (rsp_done && final_out));

   assign rsp.valid          = busy_ff;
   assign rsp.button_id      = slot_btn_ff[rd_idx_ff];
   assign rsp.event_kind     = slot_kind_ff[rd_idx_ff];
   assign rsp.changed_button = changed_ff;
   assign rsp.pressed_mask   = mask_ff;
   assign rsp.last           = final_out;

   always_ff @(posedge clock) begin
      if (pop) begin
         for (int k = 0; k < MAX_EVENTS; k++) begin
            slot_btn_ff[k]  <= slot_btn_in[k];
            slot_kind_ff[k] <= slot_kind_in[k];
         end
         last_idx_ff <= (ev_cnt == '0) ? '0 : SLOT_W'(ev_cnt - 1'b1);
         changed_ff  <= changed_in;
         mask_ff     <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ff    <= '0;
         done_ff   <= '0;
         for (int i = 0; i < NB; i++) start_ff[i] <= '0;
         busy_ff   <= 1'b0;
         rd_idx_ff <= '0;
      end else begin
         if (pop) begin
            deb_ff    <= deb_in;
            done_ff   <= done_in;
            for (int i = 0; i < NB; i++) start_ff[i] <= start_in[i];
            busy_ff   <= 1'b1;
            rd_idx_ff <= '0;
         end else if (rsp_done) begin
            if (final_out) busy_ff <= 1'b0;
            else rd_idx_ff <= rd_idx_ff + 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/button_debounce_long_press_unit.sv
// Top level: configuration registers and front/queue/back hookup.
//
//  channel  direction  handshake          payload
//  req_ch   in         valid/ready        pin_levels
//  rsp_ch   out        valid/ready        button_id, event_kind, changed_button,
//                                         pressed_mask, last
//  csr_*    in         csr_wr_en          csr_index, csr_wr_data
//
// The front takes one tick per cycle while the two-entry queue has room.
// The back pops a tick, polls buttons up to the first debounced change and
// then sends one result per cycle while rsp_ch is ready, 1 to 4 per tick.
// Synchronous reset clears control state only; no clearing pass is needed.
// A stalled rsp_ch fills the queue, which then drops req_ch ready.
`default_nettype none
module button_debounce_long_press_unit
   import bdlp_pkg::*;
#(
   parameter int NUM_BUTTONS = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   bdlp_req_if.sink                   req_ch,
   bdlp_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);
   logic            enable_ff;
   logic [MS_W-1:0] debounce_ms_ff;
   logic [MS_W-1:0] long_press_ms_ff;

   logic            q_push;
   bdlp_tick_type   q_push_data;
   logic            q_full;
   logic            q_pop;
   logic            q_empty;
   bdlp_tick_type   q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff        <= 1'b0;
         debounce_ms_ff   <= DEBOUNCE_RESET;
         long_press_ms_ff <= LONG_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENABLE:   enable_ff        <= csr_wr_data[0];
            CSR_DEBOUNCE: debounce_ms_ff   <= csr_wr_data[MS_W-1:0];
            CSR_LONG:     long_press_ms_ff <= csr_wr_data[MS_W-1:0];
            default: ;
         endcase
      end
   end

   bdlp_front #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .enable      (enable_ff),
      .debounce_ms (debounce_ms_ff),
      .queue_full  (q_full),
      .push        (q_push),
      .push_data   (q_push_data)
   );

   bdlp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   bdlp_back #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .long_press_ms (long_press_ms_ff),
      .queue_empty   (q_empty),
      .head          (q_head),
      .pop           (q_pop),
      .rsp           (rsp_ch)
   );

endmodule
`default_nettype wire
